// ===== rtl/set_assoc_cache_lru_sim_core_defines.svh =====
// Assertion macros for the set-associative cache core.
// Used by the top level only; no other dependencies.
`ifndef SET_ASSOC_CACHE_LRU_SIM_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_CORE_DEFINES_SVH

// same-cycle implication
`define SACL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sacl_pkg.sv =====
// Shared types and constants for the set-associative cache core.
// No dependencies.
package sacl_pkg;

   localparam int ADDR_W       = 64;
   localparam int TAG_W        = 64;
   localparam int IDX_W        = 15;
   localparam int RECIP_SHIFT  = IDX_W + 1;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 6;
   localparam int OUT_COUNT_W  = 32;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_IFETCH = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd2;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef struct packed {
      logic clear_row;
      logic load_req;
      logic calc_quot;
      logic read_row;
      logic match_row;
      logic write_row;
   } sacl_cmd_type;

   typedef struct packed {
      logic clear_done;
   } sacl_stat_type;

endpackage

// ===== rtl/set_assoc_cache_lru_sim_core.sv =====
// Top level of the tag-only set-associative cache core with LRU replacement.
// Instantiates sacl_ctrl and sacl_dpath; uses sacl_pkg and the defines header.
//
// After reset the block sweeps its set memories, one set per cycle, with
// req_stall high; configuration writes are taken throughout.
// A load, store or modify access has its address split at the accepting edge,
// then steps through reducing the set index modulo MAX_SETS, reading the
// set row, matching the ways, and writing the row back while loading the
// result register, which makes the result valid. The block is idle again
// at that same edge and takes no new access before then; the set row
// read-modify-write keeps one access in flight at a time. Instruction
// fetches are accepted without leaving idle and give no result. A finished
// result waits in its register while the next access proceeds; it is only
// held back at write-back if the previous result is still stalled. The csr
// port is always ready.
`include "set_assoc_cache_lru_sim_core_defines.svh"

module set_assoc_cache_lru_sim_core #(
   parameter int MAX_SETS    = 256,
   parameter int MAX_WAYS    = 8,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_opcode,
   input  logic [sacl_pkg::ADDR_W-1:0]      req_address,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_outcome,
   output logic                             rsp_extra_hit,
   output logic [sacl_pkg::OUT_COUNT_W-1:0] rsp_hit_total,
   output logic [sacl_pkg::OUT_COUNT_W-1:0] rsp_miss_total,
   output logic [sacl_pkg::OUT_COUNT_W-1:0] rsp_eviction_total,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sacl_pkg::*;

   sacl_cmd_type  cmd;
   sacl_stat_type stat;
   logic          rsp_held;
   logic          fetch_taken;

   assign csr_ready   = 1'b1;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign fetch_taken = req_valid && !req_stall && (req_opcode == OP_IFETCH);

   sacl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   sacl_dpath #(
      .MAX_SETS    (MAX_SETS),
      .MAX_WAYS    (MAX_WAYS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_opcode),
      .req_address        (req_address),
      .csr_valid          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_outcome        (rsp_outcome),
      .rsp_extra_hit      (rsp_extra_hit),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );

   `SACL_ASSERT_SAME(a_cmd_excl, clock, reset, 1'b1, $onehot0(cmd), "overlapping commands")
   `SACL_ASSERT_SAME(a_wb_free, clock, reset, cmd.write_row, !rsp_held, "result overwritten")
   `SACL_ASSERT_NEXT(a_busy_after_load, clock, reset, cmd.load_req, req_stall, "accept while busy")
   `SACL_ASSERT_NEXT(a_ifetch_quiet, clock, reset, fetch_taken, !$rose(rsp_valid), "fetch result")

endmodule

// ===== rtl/sacl_ctrl.sv =====
// Sequencer for the cache core: clear pass, then one access at a time.
// Depends on sacl_pkg.
module sacl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_opcode,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sacl_pkg::sacl_cmd_type  cmd,
   input  sacl_pkg::sacl_stat_type stat
);
   import sacl_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_QUOT  = 6'b000100,
      ST_READ  = 6'b001000,
      ST_MATCH = 6'b010000,
      ST_WRITE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd           = '0;
      cmd.clear_row = (state_ff == ST_CLEAR);
      cmd.load_req  = accept && (req_opcode != OP_IFETCH);
      cmd.calc_quot = (state_ff == ST_QUOT);
      cmd.read_row  = (state_ff == ST_READ);
      cmd.match_row = (state_ff == ST_MATCH);
      cmd.write_row = (state_ff == ST_WRITE) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && (req_opcode != OP_IFETCH)) state_in = ST_QUOT;
         end
         ST_QUOT:  state_in = ST_READ;
         ST_READ:  state_in = ST_MATCH;
         ST_MATCH: state_in = ST_WRITE;
         ST_WRITE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write_row) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/sacl_dpath.sv =====
// Datapath of the cache core: config registers, address split, set
// memories, way match, LRU update, counters and result register. Uses sacl_pkg.
module sacl_dpath #(
   parameter int MAX_SETS    = 256,
   parameter int MAX_WAYS    = 8,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sacl_pkg::sacl_cmd_type               cmd,
   output sacl_pkg::sacl_stat_type              stat,
   input  logic [1:0]                           req_opcode,
   input  logic [sacl_pkg::ADDR_W-1:0]          req_address,
   input  logic                                 csr_valid,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic [1:0]                           rsp_outcome,
   output logic                                 rsp_extra_hit,
   output logic [sacl_pkg::OUT_COUNT_W-1:0]     rsp_hit_total,
   output logic [sacl_pkg::OUT_COUNT_W-1:0]     rsp_miss_total,
   output logic [sacl_pkg::OUT_COUNT_W-1:0]     rsp_eviction_total
);
   import sacl_pkg::*;

   localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RECIP  = (1 << RECIP_SHIFT) / MAX_SETS;

   typedef logic [MAX_WAYS-1:0][WAY_W-1:0] ord_row_type;
   typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_type;

   // config
   logic [3:0] sib_ff;
   logic [3:0] ways_ff;
   logic [5:0] off_ff;

   // request
   logic               mod_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [IDX_W-1:0]   q_ff, q_in;
   logic [SET_AW-1:0]  set_ff, set_in;
   logic [SET_AW-1:0]  clr_ff;

   // set memories
   logic [MAX_WAYS-1:0] valid_mem [MAX_SETS];
   tag_row_type         tag_mem   [MAX_SETS];
   ord_row_type         ord_mem   [MAX_SETS];

   logic [MAX_WAYS-1:0] rd_valid_ff;
   tag_row_type         rd_tag_ff;
   ord_row_type         rd_ord_ff;

   // match result
   logic [WAY_W-1:0] way_ff, way_in;
   outcome_type      outc_ff, outc_in;

   // write-back
   logic [MAX_WAYS-1:0] new_valid;
   tag_row_type         new_tag;
   ord_row_type         new_ord;
   ord_row_type         ord_init;

   // counters
   logic [COUNT_WIDTH-1:0] hits_ff, misses_ff, evicts_ff;

   logic [1:0]       rsp_outcome_ff;
   logic             rsp_extra_ff;
   logic [OUT_COUNT_W-1:0] rsp_hit_ff, rsp_miss_ff, rsp_evict_ff;

   function automatic logic [COUNT_WIDTH-1:0] sat_add(
      input logic [COUNT_WIDTH-1:0] c,
      input logic [1:0]             inc
   );
      logic [COUNT_WIDTH:0] sum;
      sum = {1'b0, c} + (COUNT_WIDTH+1)'(inc);
      sat_add = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
   endfunction

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sib_ff  <= 4'd4;
         ways_ff <= 4'd1;
         off_ff  <= 6'd4;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SET_BITS:    sib_ff  <= csr_wdata[3:0];
            CSR_WAYS:        ways_ff <= csr_wdata[3:0];
            CSR_OFFSET_BITS: off_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // address split
   always_comb begin
      logic [ADDR_W-1:0] mask;
      logic [6:0]        tshift;
      mask   = (ADDR_W'(1) << sib_ff) - ADDR_W'(1);
      idx_in = IDX_W'((req_address >> off_ff) & mask);
      tshift = 7'(sib_ff) + 7'(off_ff);
      tag_in = (tshift >= 7'd64) ? '0 : (req_address >> tshift);
   end

   // set index modulo MAX_SETS by reciprocal, one correction step
   always_comb begin
      logic [31:0]      prod;
      logic [IDX_W-1:0] rem;
      prod   = 32'(idx_ff) * 32'(RECIP);
      q_in   = IDX_W'(prod >> RECIP_SHIFT);
      rem    = idx_ff - IDX_W'(32'(q_ff) * 32'(MAX_SETS));
      if (rem >= IDX_W'(MAX_SETS)) begin
         rem = rem - IDX_W'(MAX_SETS);
      end
      set_in = SET_AW'(rem);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mod_ff <= (req_opcode == OP_MODIFY);
         idx_ff <= idx_in;
         tag_ff <= tag_in;
      end
      if (cmd.calc_quot) q_ff <= q_in;
      if (cmd.read_row) set_ff <= set_in;
   end

   // clear pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_row) begin
         clr_ff <= clr_ff + SET_AW'(1);
      end
   end

   assign stat.clear_done = (clr_ff == SET_AW'(MAX_SETS - 1));

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         ord_init[w] = WAY_W'(w);
      end
   end

   // way match: first used way that hits or is free, else LRU victim
   always_comb begin
      logic [4:0] wl;
      logic       found;
      logic       fhit;
      logic [WAY_W-1:0] fw;
      logic [WAY_W-1:0] vic;
      wl = {1'b0, ways_ff};
      if (wl == 5'd0) wl = 5'd1;
      if (wl > 5'(MAX_WAYS)) wl = 5'(MAX_WAYS);
      found = 1'b0;
      fhit  = 1'b0;
      fw    = '0;
      vic   = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (5'(w) < wl) begin
            if (!rd_valid_ff[w]) begin
               found = 1'b1;
               fhit  = 1'b0;
               fw    = WAY_W'(w);
            end else if (rd_tag_ff[w] == tag_ff) begin
               found = 1'b1;
               fhit  = 1'b1;
               fw    = WAY_W'(w);
            end
         end
      end
      for (int p = 0; p < MAX_WAYS; p++) begin
         if (5'(rd_ord_ff[p]) < wl) vic = rd_ord_ff[p];
      end
      if (!found) begin
         way_in  = vic;
         outc_in = OUT_EVICT;
      end else begin
         way_in  = fw;
         outc_in = fhit ? OUT_HIT : OUT_FILL;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match_row) begin
         way_ff  <= way_in;
         outc_ff <= outc_in;
      end
   end

   // row update: mark line, move touched way to front
   always_comb begin
      logic [WAY_W-1:0] pos;
      new_valid          = rd_valid_ff;
      new_valid[way_ff]  = 1'b1;
      new_tag            = rd_tag_ff;
      new_tag[way_ff]    = tag_ff;
      pos = '0;
      for (int p = 0; p < MAX_WAYS; p++) begin
         if (rd_ord_ff[p] == way_ff) pos = WAY_W'(p);
      end
      new_ord[0] = way_ff;
      for (int p = 1; p < MAX_WAYS; p++) begin
         new_ord[p] = (WAY_W'(p) <= pos) ? rd_ord_ff[p-1] : rd_ord_ff[p];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_row) begin
         valid_mem[clr_ff] <= '0;
         ord_mem[clr_ff]   <= ord_init;
      end else if (cmd.write_row) begin
         valid_mem[set_ff] <= new_valid;
         tag_mem[set_ff]   <= new_tag;
         ord_mem[set_ff]   <= new_ord;
      end
      if (cmd.read_row) begin
         rd_valid_ff <= valid_mem[set_in];
         rd_tag_ff   <= tag_mem[set_in];
         rd_ord_ff   <= ord_mem[set_in];
      end
   end

   // counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else if (cmd.write_row) begin
         hits_ff   <= sat_add(hits_ff, 2'(outc_ff == OUT_HIT) + 2'(mod_ff));
         misses_ff <= sat_add(misses_ff, 2'(outc_ff != OUT_HIT));
         evicts_ff <= sat_add(evicts_ff, 2'(outc_ff == OUT_EVICT));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_row) begin
         rsp_outcome_ff <= outc_ff;
         rsp_extra_ff   <= mod_ff;
         rsp_hit_ff     <= OUT_COUNT_W'(sat_add(hits_ff, 2'(outc_ff == OUT_HIT) + 2'(mod_ff)));
         rsp_miss_ff    <= OUT_COUNT_W'(sat_add(misses_ff, 2'(outc_ff != OUT_HIT)));
         rsp_evict_ff   <= OUT_COUNT_W'(sat_add(evicts_ff, 2'(outc_ff == OUT_EVICT)));
      end
   end

   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_extra_hit      = rsp_extra_ff;
   assign rsp_hit_total      = rsp_hit_ff;
   assign rsp_miss_total     = rsp_miss_ff;
   assign rsp_eviction_total = rsp_evict_ff;

endmodule

// ===== dv/set_assoc_cache_lru_sim_core_test.sv =====
// Self-checking testbench for set_assoc_cache_lru_sim_core: a tag-only LRU cache
// predictor computes each access outcome and running totals, checked per response.
// Depends on sacl_pkg and the core RTL only.
module set_assoc_cache_lru_sim_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sacl_pkg::*;

   localparam int NUM_SETS    = 256;
   localparam int NUM_WAYS    = 8;
   localparam int HOLD_CYCLES = 80;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      outcome_type            outcome;
      logic                   extra_hit;
      logic [OUT_COUNT_W-1:0] hits;
      logic [OUT_COUNT_W-1:0] misses;
      logic [OUT_COUNT_W-1:0] evictions;
   } access_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_opcode = OP_LOAD;
   logic [ADDR_W-1:0]      req_address = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_outcome;
   logic                   rsp_extra_hit;
   logic [OUT_COUNT_W-1:0] rsp_hit_total;
   logic [OUT_COUNT_W-1:0] rsp_miss_total;
   logic [OUT_COUNT_W-1:0] rsp_eviction_total;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_SET_BITS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // cache predictor state
   logic [3:0]             cfg_set_bits = 4'd4;
   logic [3:0]             cfg_ways = 4'd1;
   logic [5:0]             cfg_offset_bits = 6'd4;
   bit                     line_valid [NUM_SETS][NUM_WAYS];
   logic [TAG_W-1:0]       line_tag [NUM_SETS][NUM_WAYS];
   logic [2:0]             lru_order [NUM_SETS][NUM_WAYS];
   logic [OUT_COUNT_W-1:0] hit_total = '0;
   logic [OUT_COUNT_W-1:0] miss_total = '0;
   logic [OUT_COUNT_W-1:0] evict_total = '0;
   access_result_type      lookup_results [$];
   access_result_type      want;

   int error_count = 0;
   int idle_pct = 13;
   int hold_left = 0;
   bit hold_start = 1'b0;
   bit hold_done = 1'b0;

   set_assoc_cache_lru_sim_core uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #500us;
      $display("FAIL");
      $finish;
   end

   function automatic logic [OUT_COUNT_W-1:0] bump(input logic [OUT_COUNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void cache_lookup(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
      int               tag_shift;
      logic [TAG_W-1:0] tag;
      logic [ADDR_W-1:0] idx;
      int               row;
      int               ways;
      int               way;
      int               pos;
      bit               found;
      outcome_type      kind;
      access_result_type res;
      if (op == OP_IFETCH) return;
      tag_shift = int'(cfg_set_bits) + int'(cfg_offset_bits);
      tag = (tag_shift >= 64) ? '0 : addr >> tag_shift;
      idx = (addr >> cfg_offset_bits) & ((64'd1 << cfg_set_bits) - 64'd1);
      row = int'(idx % NUM_SETS);
      ways = (cfg_ways == 0) ? 1 : (cfg_ways > NUM_WAYS) ? NUM_WAYS : int'(cfg_ways);
      kind = OUT_EVICT;
      way = 0;
      found = 0;
      for (int w = 0; w < ways && !found; w++) begin
         if (line_valid[row][w] && line_tag[row][w] == tag) begin
            kind = OUT_HIT;
            way = w;
            found = 1;
         end else if (!line_valid[row][w]) begin
            kind = OUT_FILL;
            way = w;
            found = 1;
         end
      end
      // victim is the used way that sits last in the recency list
      if (!found) begin
         for (int p = 0; p < NUM_WAYS; p++)
            if (lru_order[row][p] < ways) way = lru_order[row][p];
      end
      if (kind == OUT_HIT) begin
         hit_total = bump(hit_total);
      end else begin
         line_valid[row][way] = 1;
         line_tag[row][way] = tag;
         miss_total = bump(miss_total);
         if (kind == OUT_EVICT) evict_total = bump(evict_total);
      end
      if (op == OP_MODIFY) hit_total = bump(hit_total);
      pos = 0;
      while (pos < NUM_WAYS && lru_order[row][pos] != way) pos++;
      for (int p = pos; p > 0; p--) lru_order[row][p] = lru_order[row][p-1];
      lru_order[row][0] = 3'(way);
      res.outcome = kind;
      res.extra_hit = (op == OP_MODIFY);
      res.hits = hit_total;
      res.misses = miss_total;
      res.evictions = evict_total;
      lookup_results.push_back(res);
   endfunction

   function automatic logic [ADDR_W-1:0] compose_address(input logic [TAG_W-1:0] tag,
                                                         input logic [ADDR_W-1:0] set,
                                                         input logic [ADDR_W-1:0] low);
      int                tag_shift;
      logic [ADDR_W-1:0] a;
      tag_shift = int'(cfg_set_bits) + int'(cfg_offset_bits);
      a = low & ((64'd1 << cfg_offset_bits) - 64'd1);
      a |= (set & ((64'd1 << cfg_set_bits) - 64'd1)) << cfg_offset_bits;
      if (tag_shift < 64) a |= tag << tag_shift;
      return a;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp_val);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp_val);
      error_count++;
   endtask

   task automatic send_access(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_address <= addr;
      do @(posedge clock); while (req_stall !== 1'b0);
      cache_lookup(op, addr);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (lookup_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (index)
         CSR_SET_BITS:    cfg_set_bits = data[3:0];
         CSR_WAYS:        cfg_ways = data[3:0];
         CSR_OFFSET_BITS: cfg_offset_bits = data;
         default: ;
      endcase
   endtask

   task automatic random_access();
      int r;
      r = $urandom_range(99);
      if (r < 8)
         send_access(OP_IFETCH, rand64());
      else if (r < 20)
         send_access(2'($urandom_range(0, 2)), rand64());
      else
         send_access(2'($urandom_range(0, 2)),
                     compose_address(64'($urandom_range(0, int'(cfg_ways) + 1)),
                                     64'($urandom_range(0, 3)), rand64()));
   endtask

   // response stall, with one long hold-off
   always @(posedge clock) begin
      if (hold_start && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (lookup_results.size() == 0) begin
            report_mismatch("response with none pending", 64'(rsp_outcome), 64'd0);
         end else begin
            want = lookup_results.pop_front();
            if (rsp_outcome !== want.outcome)
               report_mismatch("outcome", 64'(rsp_outcome), 64'(want.outcome));
            if (rsp_extra_hit !== want.extra_hit)
               report_mismatch("extra_hit", 64'(rsp_extra_hit), 64'(want.extra_hit));
            if (rsp_hit_total !== want.hits)
               report_mismatch("hit_total", 64'(rsp_hit_total), 64'(want.hits));
            if (rsp_miss_total !== want.misses)
               report_mismatch("miss_total", 64'(rsp_miss_total), 64'(want.misses));
            if (rsp_eviction_total !== want.evictions)
               report_mismatch("eviction_total", 64'(rsp_eviction_total),
                               64'(want.evictions));
         end
      end
   end

   task automatic test_reset_config();
      send_access(OP_LOAD, 64'h0);
      send_access(OP_LOAD, 64'h8);
      send_access(OP_STORE, 64'h1000);
      send_access(OP_MODIFY, 64'h1004);
      send_access(OP_IFETCH, 64'h0);
      send_access(OP_LOAD, '1);
      send_access(OP_MODIFY, '1);
      send_access(OP_STORE, 64'h0);
   endtask

   task automatic test_register_extremes();
      wait_idle();
      write_csr(CSR_SET_BITS, 6'd0);
      write_csr(CSR_WAYS, 6'h0F);
      write_csr(CSR_OFFSET_BITS, 6'd1);
      send_access(OP_LOAD, 64'h2);
      send_access(OP_LOAD, 64'h4);
      send_access(OP_LOAD, 64'h6);
      wait_idle();
      write_csr(CSR_WAYS, 6'd0);
      send_access(OP_LOAD, 64'h8);
      wait_idle();
      write_csr(CSR_WAYS, 6'd2);
      send_access(OP_STORE, 64'h6);
      // tag shift past the address width: tag is zero
      wait_idle();
      write_csr(CSR_SET_BITS, 6'h3F);
      write_csr(CSR_OFFSET_BITS, 6'h3F);
      send_access(OP_LOAD, '1);
      send_access(OP_LOAD, 64'h0);
      send_access(OP_MODIFY, 64'h8000_0000_0000_0000);
      wait_idle();
      write_csr(CSR_SET_BITS, 6'd8);
      write_csr(CSR_OFFSET_BITS, 6'd32);
      write_csr(CSR_UNUSED, 6'h2A);
      send_access(OP_LOAD, 64'hFFFF_FFFF_0000_0000);
      send_access(OP_STORE, 64'hFFFF_FFFF_0000_0000);
      // set index wider than the set array wraps around
      wait_idle();
      write_csr(CSR_SET_BITS, 6'd12);
      write_csr(CSR_OFFSET_BITS, 6'd0);
      send_access(OP_LOAD, 64'h0FF);
      send_access(OP_LOAD, 64'h1FF);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         write_csr(CSR_SET_BITS, {2'($urandom), 4'($urandom_range(0, 8))});
         write_csr(CSR_WAYS, {2'($urandom), 4'($urandom_range(0, 15))});
         write_csr(CSR_OFFSET_BITS, ($urandom_range(4) == 0) ? 6'($urandom_range(0, 63))
                                                             : 6'($urandom_range(0, 8)));
         if (phase == 5) write_csr(CSR_SET_BITS, 6'($urandom_range(9, 15)));
         repeat (55) random_access();
      end
   endtask

   task automatic test_back_to_back();
      idle_pct = 0;
      repeat (40) random_access();
      idle_pct = 13;
   endtask

   task automatic test_backpressure();
      idle_pct = 0;
      for (int i = 0; i < 14; i++) begin
         if (i == 2) hold_start <= 1'b1;
         random_access();
      end
      idle_pct = 13;
   endtask

   initial begin
      for (int s = 0; s < NUM_SETS; s++)
         for (int w = 0; w < NUM_WAYS; w++) begin
            line_valid[s][w] = 0;
            line_tag[s][w] = '0;
            lru_order[s][w] = 3'(w);
         end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_register_extremes();
      test_random_traffic();
      test_back_to_back();
      test_backpressure();
      wait_idle();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== set_assoc_cache_lru_sim_core.f =====
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_ctrl.sv
rtl/sacl_dpath.sv
rtl/set_assoc_cache_lru_sim_core.sv
dv/set_assoc_cache_lru_sim_core_test.sv
